[src/byte_ring_buffer_with_delimiter_search_core_defines.svh]
// Assertion macros shared by the byte ring buffer RTL.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef BYTE_RING_BUFFER_WITH_DELIMITER_SEARCH_CORE_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_DELIMITER_SEARCH_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/brb_pkg.sv]
// Package for the byte ring buffer: field widths, operation codes and
// sequencer states. No dependencies.
`timescale 1ns / 1ps

package brb_pkg;

    localparam int BYTE_W          = 8;
    localparam int LVL_W           = 11;
    localparam int MODE_W          = 3;
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int CAP_RESET       = 1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH    = 3'd0,
        MODE_POP     = 3'd1,
        MODE_DISCARD = 3'd2,
        MODE_SEARCH  = 3'd3,
        MODE_CLEAR   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN
    } state_t;

endpackage

[src/brb_ifs.sv]
// Request and response channel interfaces of the byte ring buffer.
// Depends on brb_pkg for field widths.
`timescale 1ns / 1ps

interface brb_req_if;
    import brb_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic [LVL_W-1:0]  count;

    modport source (output valid, mode, data_byte, count, input ready);
    modport sink   (input valid, mode, data_byte, count, output ready);
endinterface

interface brb_rsp_if;
    import brb_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic [BYTE_W-1:0] data_out;
    logic [LVL_W-1:0]  amount;
    logic              found;
    logic [LVL_W-1:0]  fill_level;
    logic [LVL_W-1:0]  space_left;

    modport source (output valid, accepted, data_out, amount, found, fill_level, space_left,
                    input ready);
    modport sink   (input valid, accepted, data_out, amount, found, fill_level, space_left,
                    output ready);
endinterface

[src/byte_ring_buffer_with_delimiter_search_core.sv]
// Byte ring buffer with delimiter search. Each request carries one
// operation (push, pop, discard, search, clear) and yields exactly one
// response with the fill level and free space after it. Bytes live in a
// synchronous single-write, single-read store of STORE_DEPTH bytes; only the
// first "capacity" entries are used (zero acts as one, values above
// STORE_DEPTH act as STORE_DEPTH), and writing capacity also empties the
// buffer. Push, discard, clear, unused codes and a pop or search on an empty
// buffer load the response register at the accepting edge; a pop passes
// through S_POP because the store read data is registered; a search passes
// through S_SCAN, reading one held byte per cycle from the read point, and
// ends when the delimiter is found or the held bytes run out. The one read
// port of the store is why pop and search need these extra states.
// A new request is taken when the sequencer is idle and the response
// register is empty or being drained in the same cycle.
`timescale 1ns / 1ps
`include "byte_ring_buffer_with_delimiter_search_core_defines.svh"

module byte_ring_buffer_with_delimiter_search_core #(
    parameter int STORE_DEPTH = brb_pkg::STORE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [brb_pkg::LVL_W-1:0] cfg_wr_data,
    brb_req_if.sink                   req,
    brb_rsp_if.source                 rsp
);
    import brb_pkg::*;

    // Pointer width follows the store; sums are one bit wider than the
    // widest of pointer and level so wrap compares never overflow.
    localparam int PTR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SUM_W   = ((PTR_W > LVL_W) ? PTR_W : LVL_W) + 1;
    localparam int CAP_RST = (STORE_DEPTH < CAP_RESET) ? STORE_DEPTH : CAP_RESET;

    // Control state
    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  cap_eff_reg, cap_eff_next;
    logic [LVL_W-1:0]  held_reg, held_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [LVL_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [BYTE_W-1:0] delim_reg, delim_next;
    logic              out_valid_reg;

    // Response payload registers
    logic              accepted_reg;
    logic [BYTE_W-1:0] data_out_reg;
    logic [LVL_W-1:0]  amount_reg;
    logic              found_reg;
    logic [LVL_W-1:0]  fill_reg;
    logic [LVL_W-1:0]  space_reg;

    // Store port
    logic              mem_we;
    logic [PTR_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    // Sequencer outputs toward the response register
    logic              load_out;
    logic              res_accepted;
    logic [BYTE_W-1:0] res_data;
    logic [LVL_W-1:0]  res_amount;
    logic              res_found;

    logic              in_ready;
    logic              req_fire;

    // Wrap arithmetic
    logic [SUM_W-1:0]  cap_w;
    logic [SUM_W-1:0]  rd_plus1, wr_plus1, scan_plus1, rd_sum;
    logic [PTR_W-1:0]  rd_inc, wr_inc, scan_inc, rd_adv;
    logic [LVL_W-1:0]  drop_cnt;
    logic [LVL_W-1:0]  held_after_drop;
    logic [LVL_W-1:0]  cap_cfg;

    brb_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_ptr_reg),
        .wdata (req.data_byte),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Accept only when idle and the response register can take a result:
    // while the sequencer is busy the response register stays empty.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req.ready = in_ready;
    assign req_fire  = req.valid && in_ready;

    // Pointer advance by one wraps at the used capacity.
    assign cap_w      = SUM_W'(cap_eff_reg);
    assign rd_plus1   = SUM_W'(rd_ptr_reg) + SUM_W'(1);
    assign wr_plus1   = SUM_W'(wr_ptr_reg) + SUM_W'(1);
    assign scan_plus1 = SUM_W'(scan_ptr_reg) + SUM_W'(1);
    assign rd_inc     = (rd_plus1 >= cap_w) ? '0 : PTR_W'(rd_plus1);
    assign wr_inc     = (wr_plus1 >= cap_w) ? '0 : PTR_W'(wr_plus1);
    assign scan_inc   = (scan_plus1 >= cap_w) ? '0 : PTR_W'(scan_plus1);

    // Discard: clamp to the fill level, then advance the read point once,
    // the sum stays below twice the capacity so one subtract wraps it.
    assign drop_cnt        = (req.count < held_reg) ? req.count : held_reg;
    assign held_after_drop = held_reg - drop_cnt;
    assign rd_sum          = SUM_W'(rd_ptr_reg) + SUM_W'(drop_cnt);
    assign rd_adv          = (rd_sum >= cap_w) ? PTR_W'(rd_sum - cap_w) : PTR_W'(rd_sum);

    // Capacity write: zero acts as one, anything past the store is clipped.
    assign cap_cfg = (cfg_wr_data == '0) ? LVL_W'(1) :
                     (SUM_W'(cfg_wr_data) > SUM_W'(STORE_DEPTH)) ? LVL_W'(STORE_DEPTH) :
                     cfg_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cap_eff_reg  <= LVL_W'(CAP_RST);
            held_reg     <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            scan_ptr_reg <= '0;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_eff_reg  <= cap_eff_next;
            held_reg     <= held_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            scan_ptr_reg <= scan_ptr_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delim_reg <= delim_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cap_eff_next  = cap_eff_reg;
        held_next     = held_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_idx_next = scan_idx_reg;
        delim_next    = delim_reg;
        mem_we        = 1'b0;
        mem_raddr     = rd_ptr_reg;
        load_out      = 1'b0;
        res_accepted  = 1'b0;
        res_data      = '0;
        res_amount    = '0;
        res_found     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    delim_next = req.data_byte;
                    unique case (mode_t'(req.mode))
                        MODE_PUSH:
                        begin
                            load_out = 1'b1;
                            if (held_reg < cap_eff_reg)
                            begin
                                mem_we       = 1'b1;
                                wr_ptr_next  = wr_inc;
                                held_next    = held_reg + LVL_W'(1);
                                res_accepted = 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            // Commit the pop now; the byte arrives next cycle.
                            if (held_reg != '0)
                            begin
                                held_next  = held_reg - LVL_W'(1);
                                state_next = S_POP;
                                if (held_reg == LVL_W'(1))
                                begin
                                    rd_ptr_next = '0;
                                    wr_ptr_next = '0;
                                end
                                else
                                begin
                                    rd_ptr_next = rd_inc;
                                end
                            end
                            else
                            begin
                                load_out = 1'b1;
                            end
                        end
                        MODE_DISCARD:
                        begin
                            load_out = 1'b1;
                            if (drop_cnt != '0)
                            begin
                                res_accepted = 1'b1;
                                res_amount   = drop_cnt;
                                held_next    = held_after_drop;
                                if (held_after_drop == '0)
                                begin
                                    rd_ptr_next = '0;
                                    wr_ptr_next = '0;
                                end
                                else
                                begin
                                    rd_ptr_next = rd_adv;
                                end
                            end
                        end
                        MODE_SEARCH:
                        begin
                            // First byte is read at the read point this cycle.
                            if (held_reg == '0)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                state_next    = S_SCAN;
                                scan_idx_next = '0;
                                scan_ptr_next = rd_inc;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            load_out    = 1'b1;
                            held_next   = '0;
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                load_out     = 1'b1;
                res_accepted = 1'b1;
                res_data     = mem_rdata;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                // mem_rdata holds the byte at offset scan_idx_reg.
                if (mem_rdata == delim_reg)
                begin
                    load_out   = 1'b1;
                    res_found  = 1'b1;
                    res_amount = scan_idx_reg;
                    state_next = S_IDLE;
                end
                else if ((scan_idx_reg + LVL_W'(1)) == held_reg)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_raddr     = scan_ptr_reg;
                    scan_ptr_next = scan_inc;
                    scan_idx_next = scan_idx_reg + LVL_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Capacity writes empty the ring; user keeps them to idle, unchecked.
        if (cfg_wr_en)
        begin
            cap_eff_next = cap_cfg;
            held_next    = '0;
            rd_ptr_next  = '0;
            wr_ptr_next  = '0;
        end
    end

    // Response register: hold until drained, load when a result completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            accepted_reg <= res_accepted;
            data_out_reg <= res_data;
            amount_reg   <= res_amount;
            found_reg    <= res_found;
            fill_reg     <= held_next;
            space_reg    <= cap_eff_reg - held_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.accepted   = accepted_reg;
    assign rsp.data_out   = data_out_reg;
    assign rsp.amount     = amount_reg;
    assign rsp.found      = found_reg;
    assign rsp.fill_level = fill_reg;
    assign rsp.space_left = space_reg;

    // Checks on the buffer bookkeeping and the sequencer.
    `BRB_ASSERT_SAME(a_held_le_cap, clk, rst_n, 1'b1, held_reg <= cap_eff_reg, "fill level above capacity")
    `BRB_ASSERT_SAME(a_empty_ptrs, clk, rst_n, held_reg == '0, (rd_ptr_reg == '0) && (wr_ptr_reg == '0), "empty buffer with pointers off zero")
    `BRB_ASSERT_SAME(a_busy_out_free, clk, rst_n, state_reg != S_IDLE, !out_valid_reg, "response pending while sequencer busy")
    `BRB_ASSERT_NEXT(a_pop_result, clk, rst_n, state_reg == S_POP, out_valid_reg && accepted_reg && (state_reg == S_IDLE), "pop did not deliver its byte")

endmodule

[src/brb_store.sv]
// Byte store of the ring buffer: one write port, one read port with
// registered read data. Depends on brb_pkg for the byte width.
`timescale 1ns / 1ps

module brb_store #(
    parameter int DEPTH  = brb_pkg::STORE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [brb_pkg::BYTE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [brb_pkg::BYTE_W-1:0] rdata
);
    import brb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[tb/tb_byte_ring_buffer_with_delimiter_search_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for the byte ring buffer core: push, pop, discard, search
// and clear requests, each response checked against a local model of the ring.
// Depends on brb_pkg, the channel interfaces in brb_ifs and the core RTL.

module tb_byte_ring_buffer_with_delimiter_search_core;
    import brb_pkg::*;

    localparam int DEPTH = STORE_DEPTH_DEF;

    // Bytes that pushes and searches favor, so that searches hit at many offsets.
    localparam logic [63:0] MARK_SET = 64'h0A0D_3B7E_00FF_8055;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data_byte;
        logic [LVL_W-1:0]  count;
    } request_t;

    typedef struct packed {
        logic              accepted;
        logic [BYTE_W-1:0] data_out;
        logic [LVL_W-1:0]  amount;
        logic              found;
        logic [LVL_W-1:0]  fill_level;
        logic [LVL_W-1:0]  space_left;
    } response_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [LVL_W-1:0] cfg_wr_data;

    brb_req_if req_ch ();
    brb_rsp_if rsp_ch ();

    byte_ring_buffer_with_delimiter_search_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always #5 clk = ~clk;

    // Model of the ring: store, pointers, fill level and the capacity register.
    logic [BYTE_W-1:0] ring_bytes [DEPTH];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    int unsigned       held;
    int unsigned       capacity_reg;

    request_t    request_backlog [$];   // requests waiting for the driver
    response_t   due_results [$];       // responses owed by the core, oldest first
    int unsigned queued_total   = 0;
    int unsigned taken_total    = 0;
    int unsigned mismatch_total = 0;
    bit          stall_enable   = 1'b1;

    function automatic int unsigned usable_capacity();
        int unsigned c;
        c = capacity_reg;
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    function automatic int unsigned wrap_add(int unsigned p, int unsigned n, int unsigned cap);
        return (p + n >= cap) ? p + n - cap : p + n;
    endfunction

    function automatic void empty_ring();
        held   = 0;
        rd_ptr = 0;
        wr_ptr = 0;
    endfunction

    // Apply one request to the model and return the response it owes.
    function automatic response_t fifo_outcome(request_t r);
        response_t   res;
        int unsigned cap;
        int unsigned p;
        int unsigned n;
        cap = usable_capacity();
        res = '0;
        case (r.mode)
            MODE_PUSH:
            begin
                if (held < cap)
                begin
                    ring_bytes[wr_ptr] = r.data_byte;
                    wr_ptr = wrap_add(wr_ptr, 1, cap);
                    held++;
                    res.accepted = 1'b1;
                end
            end
            MODE_POP:
            begin
                if (held > 0)
                begin
                    res.data_out = ring_bytes[rd_ptr];
                    res.accepted = 1'b1;
                    held--;
                    if (held == 0)
                        empty_ring();
                    else
                        rd_ptr = wrap_add(rd_ptr, 1, cap);
                end
            end
            MODE_DISCARD:
            begin
                n = (r.count < held) ? r.count : held;
                res.amount = LVL_W'(n);
                if (n > 0)
                begin
                    res.accepted = 1'b1;
                    held -= n;
                    if (held == 0)
                        empty_ring();
                    else
                        rd_ptr = wrap_add(rd_ptr, n, cap);
                end
            end
            MODE_SEARCH:
            begin
                // Scan from the read point; nothing is consumed.
                p = rd_ptr;
                for (int unsigned i = 0; i < held; i++)
                begin
                    if (ring_bytes[p] == r.data_byte)
                    begin
                        res.found  = 1'b1;
                        res.amount = LVL_W'(i);
                        break;
                    end
                    p = wrap_add(p, 1, cap);
                end
            end
            MODE_CLEAR:
                empty_ring();
            default:
                ;
        endcase
        res.fill_level = LVL_W'(held);
        res.space_left = LVL_W'(cap - held);
        return res;
    endfunction

    function automatic void check_field(string name, logic [LVL_W-1:0] want,
                                        logic [LVL_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_total++;
        end
    endfunction

    function automatic void queue_request(logic [MODE_W-1:0] mode, int unsigned data,
                                          int unsigned count);
        request_t r;
        r.mode      = mode;
        r.data_byte = BYTE_W'(data);
        r.count     = LVL_W'(count);
        request_backlog.push_back(r);
        queued_total++;
    endfunction

    function automatic int unsigned pick_byte(int unsigned mark_pct);
        if ($urandom_range(99) < mark_pct)
            return 32'(MARK_SET[8 * $urandom_range(7) +: 8]);
        return $urandom_range(255);
    endfunction

    // Random traffic in alternating fill and drain stretches, so the level
    // sweeps between empty and full with random content and some noise.
    function automatic void queue_random(int unsigned n, int unsigned cap);
        bit                filling;
        int unsigned       stretch;
        int unsigned       roll;
        int unsigned       cnt;
        int unsigned       data;
        logic [MODE_W-1:0] op;
        filling = 1'b1;
        stretch = 0;
        for (int unsigned k = 0; k < n; k++)
        begin
            if (stretch == 0)
            begin
                filling = !filling;
                stretch = $urandom_range(4, (2 * cap + 8 < 60) ? 2 * cap + 8 : 60);
            end
            stretch--;
            roll = $urandom_range(99);
            if (filling)
                op = (roll < 70) ? MODE_PUSH : (roll < 80) ? MODE_POP :
                     (roll < 86) ? MODE_DISCARD : (roll < 96) ? MODE_SEARCH :
                     (roll < 98) ? MODE_CLEAR : MODE_W'(MODE_CLEAR + $urandom_range(1, 3));
            else
                op = (roll < 15) ? MODE_PUSH : (roll < 55) ? MODE_POP :
                     (roll < 70) ? MODE_DISCARD : (roll < 93) ? MODE_SEARCH :
                     (roll < 95) ? MODE_CLEAR : MODE_W'(MODE_CLEAR + $urandom_range(1, 3));
            cnt = $urandom_range(2047);
            if (op == MODE_DISCARD)
            begin
                roll = $urandom_range(99);
                cnt  = (roll < 55) ? $urandom_range(4) :
                       (roll < 80) ? $urandom_range(cap + 2) :
                       (roll < 92) ? 1024 : $urandom_range(2047);
            end
            data = pick_byte((op == MODE_SEARCH) ? 85 : 70);
            queue_request(op, data, cnt);
        end
    endfunction

    // Fill the whole store, search it end to end, then wrap both pointers.
    function automatic void queue_full_sweep();
        int unsigned b;
        for (int unsigned k = 0; k < DEPTH - 1; k++)
        begin
            b = $urandom_range(255);
            if (b == 8'hA5 || b == 8'h5A)
                b ^= 1;
            queue_request(MODE_PUSH, b, $urandom_range(2047));
        end
        queue_request(MODE_PUSH, 8'hA5, 0);                   // fills the last entry
        queue_request(MODE_PUSH, $urandom_range(255), 0);     // refused: buffer full
        queue_request(MODE_SEARCH, 8'hA5, 0);                 // found at the far end
        queue_request(MODE_SEARCH, 8'h5A, 0);                 // full scan, no match
        queue_request(MODE_DISCARD, 0, 1000);
        queue_request(MODE_PUSH, 8'h5A, 0);                   // lands at entry zero
        for (int unsigned k = 0; k < 30; k++)
            queue_request(MODE_PUSH, $urandom_range(255), $urandom_range(2047));
        queue_request(MODE_SEARCH, 8'h5A, 0);                 // match past the wrap
        for (int unsigned k = 0; k < 30; k++)
            queue_request(MODE_POP, $urandom_range(255), $urandom_range(2047));
        queue_request(MODE_DISCARD, 0, 1024);                 // clamped, empties
    endfunction

    // Hold until every queued request is taken and every response is back.
    task automatic drain_all();
        do
            @(posedge clk);
        while (taken_total != queued_total || due_results.size() != 0);
    endtask

    // Write capacity with the core idle; the write also empties the buffer.
    task automatic set_capacity(int unsigned value);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LVL_W'(value);
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        capacity_reg = value;
        empty_ring();
    endtask

    // Request driver: predict each request at its handshake, then advance to
    // the next one from the backlog, idling at random while stalls are on.
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        request_t seen;
        request_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen = {req_ch.mode, req_ch.data_byte, req_ch.count};
                due_results.push_back(fifo_outcome(seen));
                taken_total++;
            end
            // Hold the current request until it is taken.
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_backlog.size() > 0 && !(stall_enable && $urandom_range(99) < 32))
                begin
                    nxt = request_backlog.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.mode      <= nxt.mode;
                    req_ch.data_byte <= nxt.data_byte;
                    req_ch.count     <= nxt.count;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compare each response with the oldest owed one and
    // stall the response channel at random while stalls are on.
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        response_t got;
        response_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.accepted, rsp_ch.data_out, rsp_ch.amount, rsp_ch.found,
                       rsp_ch.fill_level, rsp_ch.space_left};
                if (due_results.size() == 0)
                begin
                    $display("%0t: stray response, expected none, actual %p", $time, got);
                    mismatch_total++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("accepted", LVL_W'(want.accepted), LVL_W'(got.accepted));
                    check_field("data_out", LVL_W'(want.data_out), LVL_W'(got.data_out));
                    check_field("amount", want.amount, got.amount);
                    check_field("found", LVL_W'(want.found), LVL_W'(got.found));
                    check_field("fill_level", want.fill_level, got.fill_level);
                    check_field("space_left", want.space_left, got.space_left);
                end
            end
            rsp_ch.ready <= !(stall_enable && $urandom_range(99) < 32);
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = '0;
        req_ch.data_byte   = '0;
        req_ch.count       = '0;
        rsp_ch.ready       = 1'b0;
        capacity_reg       = CAP_RESET;
        empty_ring();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on a three-byte ring: empty, full and wrap corners.
        set_capacity(3);
        queue_request(MODE_POP, 8'hFF, 2047);          // pop on empty
        queue_request(MODE_DISCARD, 0, 5);             // discard on empty
        queue_request(MODE_SEARCH, 8'h00, 0);          // search on empty
        queue_request(MODE_PUSH, 8'h00, 0);
        queue_request(MODE_PUSH, 8'hFF, 0);
        queue_request(MODE_PUSH, 8'h80, 0);
        queue_request(MODE_PUSH, 8'h55, 0);            // refused: full
        queue_request(MODE_SEARCH, 8'h80, 0);          // last held byte
        queue_request(MODE_SEARCH, 8'h00, 0);          // byte at the read point
        queue_request(MODE_SEARCH, 8'h12, 0);          // no match
        queue_request(MODE_DISCARD, 8'hFF, 0);         // zero count
        queue_request(MODE_POP, 8'h00, 0);
        queue_request(MODE_PUSH, 8'h7F, 0);            // lands at entry zero past the wrap
        queue_request(MODE_DISCARD, 0, 2047);          // clamped to the level
        queue_request(MODE_PUSH, 8'h01, 0);
        queue_request(MODE_PUSH, 8'hAA, 0);
        queue_request(MODE_CLEAR, 8'hFF, 1024);
        queue_request(MODE_W'(MODE_CLEAR + 1), 8'hFF, 1024);   // unused codes: no-op
        queue_request(MODE_W'(MODE_CLEAR + 2), 8'h00, 0);
        queue_request(MODE_W'(MODE_CLEAR + 3), 8'h5A, 2047);
        queue_request(MODE_PUSH, 8'h3C, 0);
        queue_request(MODE_DISCARD, 0, 1024);

        // Oversized capacity acts as the full store; run it with no idling.
        stall_enable <= 1'b0;
        set_capacity(2047);
        queue_full_sweep();
        drain_all();
        stall_enable <= 1'b1;

        set_capacity(0);                               // acts as one
        queue_random(80, usable_capacity());
        set_capacity(1);
        queue_random(80, usable_capacity());
        set_capacity(5);
        queue_random(150, usable_capacity());
        set_capacity(16);
        queue_random(75, usable_capacity());
        drain_all();                                   // hold the sender until all is back
        queue_random(75, usable_capacity());
        set_capacity(100);
        queue_random(150, usable_capacity());
        set_capacity(1025);
        queue_random(80, usable_capacity());
        set_capacity(37);
        queue_random(120, usable_capacity());
        set_capacity(1024);
        queue_random(60, usable_capacity());

        drain_all();
        repeat (40) @(posedge clk);
        if (mismatch_total == 0 && due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: a correct run ends far sooner.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
